[sv/otsu_threshold_binarizer_core_macros.svh]
// assertion macros for the otsu threshold binarizer
// no dependencies
`ifndef OTSU_THRESHOLD_BINARIZER_CORE_MACROS_SVH
`define OTSU_THRESHOLD_BINARIZER_CORE_MACROS_SVH

// same-cycle implication
`define OTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("otsu check failed");

// next-cycle implication
`define OTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("otsu check failed");

`endif

[sv/otb_pkg.sv]
// shared constants for the otsu threshold binarizer
// no dependencies
`default_nettype none
package otb_pkg;
    localparam int PIX_W = 8;
    localparam logic RK_THRESH = 1'b0;
    localparam logic RK_PIXEL  = 1'b1;
    localparam logic KIND_HIST = 1'b0;
    localparam logic KIND_BIN  = 1'b1;
    localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;
    localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;
endpackage
`default_nettype wire

[sv/otb_hist.sv]
// histogram memory, one write and one registered read port
// no dependencies
`default_nettype none
module otb_hist #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 23
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

[sv/otb_div.sv]
// shared restoring divider, one quotient bit per cycle
// uses otb_pkg
`default_nettype none
module otb_div #(
    parameter int NW = 30,
    parameter int DW = 23
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic      [NW-1:0] o_quot
);
    import otb_pkg::*;
    localparam int CNW = $clog2(NW + 1);

    logic [DW:0]    r_rem;
    logic [DW-1:0]  r_den;
    logic [CNW-1:0] r_cnt;
    logic           r_run;
    logic [DW:0]    n_shift;
    logic           n_bit;

    always_comb begin
        n_shift = {r_rem[DW-1:0], o_quot[NW-1]};
        n_bit   = (n_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= CNW'(NW);
                r_rem  <= '0;
                r_den  <= i_den;
                o_quot <= i_num;
            end else if (r_run) begin
                r_rem  <= n_bit ? (n_shift - {1'b0, r_den}) : n_shift;
                o_quot <= {o_quot[NW-2:0], n_bit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[sv/otsu_threshold_binarizer_core.sv]
// otsu threshold binarizer top level: sequencer, histogram and sweep
// uses otb_pkg, otb_hist, otb_div and the assertion macro header
//
// usage: drive i_kind, i_pixel_value, i_last_pixel with start; a word is
// taken at a clock edge where start is high and busy is low.
// kind 1 word: binarized pixel on o_value in the cycle after it is taken, o_strobe high
// for one cycle, o_result_kind = 1.
// kind 0 word: counted into the histogram (memory read, then write of the
// incremented bin) while under 2**MAX_PIXELS_LOG2 pixels are counted;
// no result unless i_last_pixel is set.
// last pixel: the bins are swept, first for the total sum (read, accumulate),
// then bin by bin (read, accumulate and clear, check, advance); a bin with
// both classes nonempty adds two serial divisions on the shared divider and
// the multiply and compare steps. The threshold appears with
// o_result_kind = 0.
// reset: a clearing pass zeroes the histogram bin by bin, busy high.
// the receiver cannot stall: every result is valid for exactly one cycle.
`default_nettype none
`include "otsu_threshold_binarizer_core_macros.svh"
module otsu_threshold_binarizer_core #(
    parameter int BINS            = 256,
    parameter int MAX_PIXELS_LOG2 = 22
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_kind,
    input  wire logic [otb_pkg::PIX_W-1:0] i_pixel_value,
    input  wire logic                     i_last_pixel,
    output logic                          o_strobe,
    output logic                          o_result_kind,
    output logic      [otb_pkg::PIX_W-1:0] o_value
);
    import otb_pkg::*;

    localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW = MAX_PIXELS_LOG2 + 1;
    localparam int SW = CW + BW;
    localparam int PW = 2 * CW + 2 * BW;
    localparam logic [BW-1:0] BIN_LAST = BW'(BINS - 1);
    localparam logic [PIX_W:0] BINS_X = (PIX_W + 1)'(BINS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INC, S_SUM_RD, S_SUM_ACC, S_SW_RD, S_SW_ACC,
        S_SW_CHK, S_DIV_B, S_DIV_F, S_MUL1, S_MUL2, S_MUL3, S_CMP, S_NEXT
    } t_state;

    t_state         r_state;
    logic [BW-1:0]  r_idx;
    logic [BW-1:0]  r_bin;
    logic           r_last;
    logic [CW-1:0]  r_count;
    logic [BW-1:0]  r_thr;
    logic [SW-1:0]  r_sum_all;
    logic [CW-1:0]  r_cnt_b;
    logic [SW-1:0]  r_sum_b;
    logic [BW-1:0]  r_mean_b;
    logic [BW-1:0]  r_diff;
    logic [PW-1:0]  r_prod;
    logic [PW-1:0]  r_best;
    logic [BW-1:0]  r_best_bin;

    logic          accept;
    logic [BW-1:0] pix_bin;
    logic          mem_wr_en;
    logic [BW-1:0] mem_wr_addr;
    logic [CW-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [BW-1:0] mem_rd_addr;
    logic [CW-1:0] mem_rd_data;
    logic          div_start;
    logic [SW-1:0] div_num;
    logic [CW-1:0] div_den;
    logic          div_done;
    logic [SW-1:0] div_quot;
    logic [BW-1:0] mean_f;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign pix_bin = ({1'b0, i_pixel_value} < BINS_X) ? BW'(i_pixel_value) : BIN_LAST;
    assign mean_f  = div_quot[BW-1:0];

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_idx;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_idx;
        div_start   = 1'b0;
        div_num     = r_sum_b;
        div_den     = r_cnt_b;
        case (r_state)
            S_CLEAR: begin
                mem_wr_en = 1'b1;
            end
            S_IDLE: begin
                mem_rd_en   = accept && (i_kind == KIND_HIST);
                mem_rd_addr = pix_bin;
            end
            S_INC: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_bin;
                mem_wr_data = mem_rd_data + 1'b1;
            end
            S_SUM_RD, S_SW_RD: begin
                mem_rd_en = 1'b1;
            end
            S_SW_ACC: begin
                mem_wr_en = 1'b1;
            end
            S_SW_CHK: begin
                div_start = (r_cnt_b != '0) && (r_cnt_b < r_count);
            end
            S_DIV_B: begin
                div_start = div_done;
                div_num   = r_sum_all - r_sum_b;
                div_den   = r_count - r_cnt_b;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_count  <= '0;
            r_thr    <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == BIN_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_idx      <= '0;
                    r_sum_all  <= '0;
                    r_cnt_b    <= '0;
                    r_sum_b    <= '0;
                    r_best     <= '0;
                    r_best_bin <= '0;
                    if (accept) begin
                        if (i_kind == KIND_BIN) begin
                            o_strobe      <= 1'b1;
                            o_result_kind <= RK_PIXEL;
                            o_value       <= (i_pixel_value >= PIX_W'(r_thr)) ?
                                             PIX_LOW : PIX_HIGH;
                        end else if (!r_count[CW-1]) begin
                            r_bin   <= pix_bin;
                            r_last  <= i_last_pixel;
                            r_state <= S_INC;
                        end else if (i_last_pixel) begin
                            r_state <= S_SUM_RD;
                        end
                    end
                end
                S_INC: begin
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? S_SUM_RD : S_IDLE;
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_sum_all <= r_sum_all + SW'(r_idx) * SW'(mem_rd_data);
                    r_idx     <= r_idx + 1'b1;
                    r_state   <= S_SUM_RD;
                    if (r_idx == BIN_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_SW_RD;
                    end
                end
                S_SW_RD: begin
                    r_state <= S_SW_ACC;
                end
                S_SW_ACC: begin
                    r_cnt_b <= r_cnt_b + mem_rd_data;
                    r_sum_b <= r_sum_b + SW'(r_idx) * SW'(mem_rd_data);
                    r_state <= S_SW_CHK;
                end
                S_SW_CHK: begin
                    r_state <= div_start ? S_DIV_B : S_NEXT;
                end
                S_DIV_B: begin
                    if (div_done) begin
                        r_mean_b <= div_quot[BW-1:0];
                        r_state  <= S_DIV_F;
                    end
                end
                S_DIV_F: begin
                    if (div_done) begin
                        r_diff  <= (r_mean_b >= mean_f) ? r_mean_b - mean_f
                                                        : mean_f - r_mean_b;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_prod  <= PW'(r_cnt_b) * PW'(r_count - r_cnt_b);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= r_prod * PW'(r_diff);
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_prod  <= r_prod * PW'(r_diff);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_prod >= r_best) begin
                        r_best     <= r_prod;
                        r_best_bin <= r_idx;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SW_RD;
                    if (r_idx == BIN_LAST) begin
                        r_idx         <= '0;
                        r_thr         <= r_best_bin;
                        r_count       <= '0;
                        o_strobe      <= 1'b1;
                        o_result_kind <= RK_THRESH;
                        o_value       <= PIX_W'(r_best_bin);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    otb_hist #(
        .DEPTH (BINS),
        .AW    (BW),
        .DW    (CW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    otb_div #(
        .NW (SW),
        .DW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    `OTB_ASSERT_NEXT(a_pix_result, i_clk, i_rst_n, accept && (i_kind == KIND_BIN), o_strobe && (o_result_kind == RK_PIXEL))
    `OTB_ASSERT_NEXT(a_hist_quiet, i_clk, i_rst_n, accept && (i_kind == KIND_HIST), !o_strobe)
    `OTB_ASSERT_NOW(a_thr_idle, i_clk, i_rst_n, o_strobe && (o_result_kind == RK_THRESH), !busy)
    `OTB_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, r_count[CW-1], r_count[CW-2:0] == '0)
endmodule
`default_nettype wire

[dv/otsu_threshold_binarizer_core_tb.sv]
// self-checking testbench for otsu_threshold_binarizer_core: histogram frames, sweeps, binarize words
// depends on otb_pkg and the otsu_threshold_binarizer_core rtl
`default_nettype none
module otsu_threshold_binarizer_core_tb;
    import otb_pkg::*;

    localparam int NBINS    = 256;
    localparam int MAXPIX_LOG2 = 22;
    localparam int WDOG_MAX = 200000;

    typedef struct packed {
        logic                 rkind;
        logic [PIX_W-1:0]     val;
    } otsu_res_t;

    class otsu_scoreboard;
        longint unsigned hist[NBINS];
        longint unsigned count;
        logic [PIX_W-1:0] thresh;
        otsu_res_t pending[$];
        int errors;
        int words_in;
        int thresholds;
        int pixels_out;

        function new();
            foreach (hist[k]) hist[k] = 0;
            count = 0;
            thresh = '0;
            errors = 0;
            words_in = 0;
            thresholds = 0;
            pixels_out = 0;
        endfunction

        function logic [PIX_W-1:0] best_split();
            longint unsigned sum_all, cnt_b, sum_b, best, mb, mf, d, score;
            int best_bin;
            sum_all = 0;
            cnt_b = 0;
            sum_b = 0;
            best = 0;
            best_bin = 0;
            for (int k = 0; k < NBINS; k++) sum_all += k * hist[k];
            for (int k = 0; k < NBINS; k++) begin
                cnt_b += hist[k];
                sum_b += k * hist[k];
                if (cnt_b == 0 || cnt_b >= count) continue;
                mb = sum_b / cnt_b;
                mf = (sum_all - sum_b) / (count - cnt_b);
                d = (mb >= mf) ? mb - mf : mf - mb;
                score = cnt_b * (count - cnt_b) * d * d;
                if (score >= best) begin
                    best = score;
                    best_bin = k;
                end
            end
            return best_bin[PIX_W-1:0];
        endfunction

        function void note_word(logic kind, logic [PIX_W-1:0] pix, logic last);
            otsu_res_t r;
            words_in++;
            if (kind == KIND_BIN) begin
                r.rkind = RK_PIXEL;
                r.val = (pix >= thresh) ? PIX_LOW : PIX_HIGH;
                pending.push_back(r);
                return;
            end
            if (count < (64'd1 << MAXPIX_LOG2)) begin
                hist[pix]++;
                count++;
            end
            if (last) begin
                thresh = best_split();
                foreach (hist[k]) hist[k] = 0;
                count = 0;
                r.rkind = RK_THRESH;
                r.val = thresh;
                pending.push_back(r);
            end
        endfunction

        function void check_word(logic rkind, logic [PIX_W-1:0] val);
            otsu_res_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word: result_kind %0d value %0d", rkind, val);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.rkind == RK_THRESH) thresholds++;
            else pixels_out++;
            if (rkind !== e.rkind) begin
                $error("result_kind mismatch: expected %0d actual %0d", e.rkind, rkind);
                errors++;
            end
            if (val !== e.val) begin
                $error("value mismatch: expected %0d actual %0d", e.val, val);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic i_kind = 1'b0;
    logic [PIX_W-1:0] i_pixel_value = '0;
    logic i_last_pixel = 1'b0;
    logic busy;
    logic o_strobe;
    logic o_result_kind;
    logic [PIX_W-1:0] o_value;

    otsu_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;

    always #6 i_clk = ~i_clk;

    otsu_threshold_binarizer_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_pixel_value(i_pixel_value), .i_last_pixel(i_last_pixel),
        .o_strobe(o_strobe), .o_result_kind(o_result_kind), .o_value(o_value)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_word(o_result_kind, o_value);
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one word; called right after a rising edge
    task automatic send_word(logic kind, logic [PIX_W-1:0] pix, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_kind <= kind;
        i_pixel_value <= pix;
        i_last_pixel <= last;
        do @(posedge i_clk); while (busy);
        sb.note_word(kind, pix, last);
    endtask

    task automatic send_frame(int n, int mode);
        logic [PIX_W-1:0] a, b, p;
        a = PIX_W'($urandom_range(0, 255));
        b = PIX_W'($urandom_range(0, 255));
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: p = PIX_W'($urandom_range(0, 255));
                1: p = PIX_W'(($urandom_range(0, 1) ? a : b) + $urandom_range(0, 3));
                default: p = a;
            endcase
            send_word(KIND_HIST, p, k == n - 1);
        end
    endtask

    task automatic send_binarize(int n);
        for (int k = 0; k < n; k++)
            send_word(KIND_BIN, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // binarize before any sweep, extremes, last flag ignored
        send_word(KIND_BIN, 8'd0, 1'b1);
        send_word(KIND_BIN, 8'd255, 1'b0);
        send_word(KIND_BIN, 8'd128, 1'b1);
        // single pixel frame: no valid split
        send_word(KIND_HIST, 8'd255, 1'b1);
        send_word(KIND_BIN, 8'd0, 1'b0);
        // two equal pixels: no valid split
        send_word(KIND_HIST, 8'd77, 1'b0);
        send_word(KIND_HIST, 8'd77, 1'b1);
        // splits tied across the gap between two pixels go to the last tied bin
        send_word(KIND_HIST, 8'd10, 1'b0);
        send_word(KIND_HIST, 8'd20, 1'b1);
        send_word(KIND_BIN, 8'd18, 1'b0);
        send_word(KIND_BIN, 8'd19, 1'b0);
        send_word(KIND_BIN, 8'd20, 1'b0);
        // extreme bins
        send_word(KIND_HIST, 8'd0, 1'b0);
        send_word(KIND_HIST, 8'd255, 1'b0);
        send_word(KIND_HIST, 8'd0, 1'b1);
        send_word(KIND_BIN, 8'd0, 1'b0);
        send_word(KIND_BIN, 8'd255, 1'b1);

        while (sb.words_in < 1050) begin
            send_frame($urandom_range(1, 30), $urandom_range(0, 9) < 2 ? 2 :
                       $urandom_range(0, 1));
            send_binarize($urandom_range(3, 30));
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d words, %0d thresholds and %0d binarized pixels checked",
                 sb.words_in, sb.thresholds, sb.pixels_out);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[otsu_threshold_binarizer_core.f]
+incdir+sv
sv/otb_pkg.sv
sv/otb_hist.sv
sv/otb_div.sv
sv/otsu_threshold_binarizer_core.sv
dv/otsu_threshold_binarizer_core_tb.sv
